// ----- rtl/mono_oled_page_buffer_flusher_assert.svh -----
// ----------------------------------------------------------------------------
// mono_oled_page_buffer_flusher_assert.svh
// Assertion macros for the page buffer flusher.
// ----------------------------------------------------------------------------
`ifndef MONO_OLED_PAGE_BUFFER_FLUSHER_ASSERT_SVH
`define MONO_OLED_PAGE_BUFFER_FLUSHER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MOPF_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MOPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mopf_pkg.sv -----
// ----------------------------------------------------------------------------
// mopf_pkg
// Shared opcodes, panel constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mopf_pkg;

  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;

  localparam int PAGE_W    = 3;
  localparam int CMD_BYTES = 3;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] BYTE_ALL_ON   = 8'hFF;

  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_FILL  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_PULL  = 2'd3;

  typedef struct packed {
    logic accept;
    logic sweep_write;
    logic draw_write;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flush_active;
    logic out_free;
    logic sweep_last;
  } dp_status_t;

endpackage

// ----- rtl/mopf_ctrl.sv -----
// ----------------------------------------------------------------------------
// mopf_ctrl
// Sequencer for clearing sweeps, pixel read-modify-write and byte pulls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mopf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            op,
  output logic                  in_ready,
  input  mopf_pkg::dp_status_t  status,
  output mopf_pkg::ctrl_cmd_t   cmd
);
  import mopf_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_DRAW  = 2'd2;
  localparam logic [1:0] ST_PULL  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    cmd.accept       = accept;
    cmd.sweep_write  = 1'b0;
    cmd.draw_write   = 1'b0;
    cmd.load_out     = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.sweep_write = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_DRAW:  state_next = ST_DRAW;
            OP_FILL:  state_next = ST_CLEAR;
            OP_START: state_next = ST_IDLE;
            OP_PULL:  state_next = status.flush_active ? ST_PULL : ST_IDLE;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        cmd.draw_write = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_PULL: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- rtl/mopf_dp.sv -----
// ----------------------------------------------------------------------------
// mopf_dp
// Frame store, flush position counters and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mopf_dp #(
  parameter int PANEL_WIDTH  = mopf_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mopf_pkg::DEF_PANEL_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            op,
  input  logic [7:0]            x,
  input  logic [7:0]            y,
  input  logic [15:0]           color,
  input  mopf_pkg::ctrl_cmd_t   cmd,
  output mopf_pkg::dp_status_t  status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_byte,
  output logic                  is_data,
  output logic                  last
);
  import mopf_pkg::*;

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int POS_W       = $clog2(PANEL_WIDTH + CMD_BYTES);

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rdata;

  logic [ADDR_W-1:0] sweep_cnt;
  logic              fill_on;

  logic              flush_active;
  logic [PAGE_W-1:0] flush_page;
  logic [POS_W-1:0]  page_pos;

  logic [ADDR_W-1:0] wr_addr;
  logic [2:0]        draw_bit;
  logic              draw_set;
  logic              draw_hit;

  logic [7:0]        pend_cmd;
  logic              pend_is_data;
  logic              pend_last;

  logic              hit_c;
  logic [ADDR_W-1:0] draw_addr;
  logic [ADDR_W-1:0] pull_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              pos_end;
  logic              page_end;
  logic [7:0]        cmd_byte;
  logic [7:0]        draw_mask;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;

  assign hit_c     = (int'(x) < PANEL_WIDTH) && (int'(y) < PANEL_HEIGHT);
  assign draw_addr = ADDR_W'(int'(x) + int'(y[7:3]) * PANEL_WIDTH);
  assign pull_addr = ADDR_W'(int'(flush_page) * PANEL_WIDTH + int'(page_pos) - CMD_BYTES);
  assign rd_addr   = (op == OP_PULL) ? pull_addr : draw_addr;
  assign pos_end   = (page_pos == POS_W'(PANEL_WIDTH + CMD_BYTES - 1));
  assign page_end  = (flush_page == PAGE_W'(PAGE_COUNT - 1));
  assign draw_mask = 8'(1) << draw_bit;

  always_comb begin
    case (page_pos)
      POS_W'(0): cmd_byte = CMD_PAGE_BASE + {{(8 - PAGE_W){1'b0}}, flush_page};
      POS_W'(1): cmd_byte = CMD_COL_LOW;
      POS_W'(2): cmd_byte = CMD_COL_HIGH;
      default:   cmd_byte = CMD_COL_LOW;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = wr_addr;
    wdata = draw_set ? (rdata | draw_mask) : (rdata & ~draw_mask);
    if (cmd.sweep_write) begin
      we    = 1'b1;
      waddr = sweep_cnt;
      wdata = fill_on ? BYTE_ALL_ON : 8'h00;
    end else if (cmd.draw_write && draw_hit) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.accept) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      wr_addr      <= draw_addr;
      draw_bit     <= y[2:0];
      draw_set     <= (color != 16'd0);
      draw_hit     <= hit_c;
      pend_cmd     <= cmd_byte;
      pend_is_data <= (int'(page_pos) >= CMD_BYTES);
      pend_last    <= pos_end && page_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt    <= '0;
      fill_on      <= 1'b0;
      flush_active <= 1'b0;
      flush_page   <= '0;
      page_pos     <= '0;
    end else begin
      if (cmd.sweep_write) begin
        sweep_cnt <= (sweep_cnt == ADDR_W'(STORE_BYTES - 1)) ? '0 : sweep_cnt + 1'b1;
      end
      if (cmd.accept && op == OP_FILL) begin
        fill_on <= (color != 16'd0);
      end
      if (cmd.accept && op == OP_START) begin
        flush_active <= 1'b1;
        flush_page   <= '0;
        page_pos     <= '0;
      end else if (cmd.accept && op == OP_PULL && flush_active) begin
        if (pos_end) begin
          page_pos <= '0;
          if (page_end) begin
            flush_active <= 1'b0;
            flush_page   <= '0;
          end else begin
            flush_page <= flush_page + 1'b1;
          end
        end else begin
          page_pos <= page_pos + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte <= pend_is_data ? rdata : pend_cmd;
      is_data  <= pend_is_data;
      last     <= pend_last;
    end
  end

  assign status.flush_active = flush_active;
  assign status.out_free     = !out_valid || out_ready;
  assign status.sweep_last   = (sweep_cnt == ADDR_W'(STORE_BYTES - 1));

endmodule

// ----- rtl/mono_oled_page_buffer_flusher.sv -----
// ----------------------------------------------------------------------------
// mono_oled_page_buffer_flusher
// Page-organized 1-bpp frame store with a panel flush byte streamer.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the frame store, one byte per
// cycle (PANEL_WIDTH * ceil(PANEL_HEIGHT / 8) bytes, 1024 at the defaults),
// with in_ready low. A draw is a registered read, then a write back of the
// modified byte through the single store write port. A pull waits for the
// output register to free up, and a fill sweeps the whole store at one byte
// per cycle. A pull with no flush armed gives no transaction on the output.
`timescale 1ns / 1ps

module mono_oled_page_buffer_flusher #(
  parameter int PANEL_WIDTH  = mopf_pkg::DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = mopf_pkg::DEF_PANEL_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  x,
  input  logic [7:0]  y,
  input  logic [15:0] color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        is_data,
  output logic        last
);
  import mopf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mopf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mopf_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .x         (x),
    .y         (y),
    .color     (color),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last      (last)
  );

`include "mono_oled_page_buffer_flusher_assert.svh"

  `MOPF_ASSERT_IMPLIES(a_load_slot_free, cmd.load_out, !out_valid || out_ready, "load into busy output")
  `MOPF_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid, "loaded byte not shown")
  `MOPF_ASSERT_IMPLIES(a_last_is_data, out_valid && last, is_data, "last on a command byte")
  `MOPF_ASSERT_IMPLIES(a_no_accept_in_sweep, cmd.sweep_write, !in_ready, "accept during sweep")

endmodule

// ----- tb/sv/mono_oled_page_buffer_flusher_test.sv -----
// ----------------------------------------------------------------------------
// mono_oled_page_buffer_flusher_test
// Self-checking bench for the page buffer flusher: a directed table of draws,
// fills, starts and pulls, then a random mix of draws, fills, starts and pulls.
// A shadow frame store predicts the streamed bytes where the table gives none,
// and transactions are checked in order under varied sender and receiver idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mono_oled_page_buffer_flusher_test;
  import mopf_pkg::*;

  localparam int W      = DEF_PANEL_WIDTH;
  localparam int H      = DEF_PANEL_HEIGHT;
  localparam int PAGES  = (H + 7) / 8;
  localparam int STORE  = W * PAGES;
  localparam int MIN_ITEMS = 920;
  localparam int PHASE_LEN = 150;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       last;
  } panel_byte_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [15:0] color;
    logic        chk;
    panel_byte_t want;
  } step_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_DRAW;
  logic [7:0]  x = 8'd0;
  logic [7:0]  y = 8'd0;
  logic [15:0] color = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        is_data;
  logic        last;

  logic [7:0]  shadow_store [STORE];
  bit          flush_on;
  int          flush_pg;
  int          flush_pos;

  panel_byte_t pending_bytes [$];
  int          mismatches;
  int          phase;
  bit          hold_req;
  bit          full_run;

  step_row_t   plan [23];

  mono_oled_page_buffer_flusher u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .x         (x),
    .y         (y),
    .color     (color),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .is_data   (is_data),
    .last      (last)
  );

  always #5 clk = ~clk;

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic predict_panel_byte(input logic [1:0] o, input logic [7:0] px,
                                    input logic [7:0] py, input logic [15:0] c,
                                    output bit has, output panel_byte_t res);
    int idx;
    has = 1'b0;
    res = '0;
    case (o)
      OP_DRAW: begin
        if (px < W && py < H) begin
          idx = px + (py >> 3) * W;
          shadow_store[idx][py[2:0]] = (c != 16'd0);
        end
      end
      OP_FILL: begin
        foreach (shadow_store[i]) shadow_store[i] = (c != 16'd0) ? BYTE_ALL_ON : 8'h00;
      end
      OP_START: begin
        flush_on  = 1'b1;
        flush_pg  = 0;
        flush_pos = 0;
      end
      default: begin
        if (flush_on) begin
          has = 1'b1;
          if (flush_pos == 0) res.data = CMD_PAGE_BASE + 8'(flush_pg);
          else if (flush_pos == 1) res.data = CMD_COL_LOW;
          else if (flush_pos == 2) res.data = CMD_COL_HIGH;
          else begin
            res.data    = shadow_store[flush_pg * W + flush_pos - CMD_BYTES];
            res.is_data = 1'b1;
          end
          if (flush_pos + 1 >= CMD_BYTES + W) begin
            flush_pos = 0;
            if (flush_pg + 1 >= PAGES) begin
              res.last = 1'b1;
              flush_on = 1'b0;
              flush_pg = 0;
            end else begin
              flush_pg++;
            end
          end else begin
            flush_pos++;
          end
        end
      end
    endcase
  endtask

  function automatic int sender_gap();
    int g;
    int pct;
    g = 0;
    pct = (phase == 1) ? 56 : (phase == 3) ? 24 : 0;
    while (g < 12 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  // hold valid until the transaction, then predict; returns at a falling edge
  task automatic send_item(input logic [1:0] o, input logic [7:0] px, input logic [7:0] py,
                           input logic [15:0] c, input logic chk, input panel_byte_t want);
    int gap;
    bit has;
    panel_byte_t res;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    x        <= px;
    y        <= py;
    color    <= c;
    do @(posedge clk); while (!in_ready);
    predict_panel_byte(o, px, py, c, has, res);
    if (chk) pending_bytes.push_back(want);
    else if (has) pending_bytes.push_back(res);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_bytes.size() != 0);
  endtask

  task automatic note_miss(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %02h, got %02h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    panel_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        note_miss("unexpected transaction, out_byte", 8'h00, out_byte);
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) note_miss("out_byte", want.data, out_byte);
        if (is_data !== want.is_data) note_miss("is_data", 8'(want.is_data), 8'(is_data));
        if (last !== want.last) note_miss("last", 8'(want.last), 8'(last));
      end
    end
  end

  initial begin : receiver
    int hold_left;
    int pct;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
      end
      pct = (phase == 2) ? 56 : (phase == 3) ? 24 : 0;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= pct);
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          next_phase;
    int          r;
    bit          ignored;
    bit          hold_done;
    logic [1:0]  o;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [15:0] c;

    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    flush_on  = 1'b0;
    flush_pg  = 0;
    flush_pos = 0;
    phase     = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    full_run  = 1'b0;
    n         = 0;

    plan = '{
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_DRAW,  8'd0,   8'd0,   16'h0001, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_DRAW,  8'd127, 8'd63,  16'hFFFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_DRAW,  8'd128, 8'd0,   16'h0001, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_DRAW,  8'd0,   8'd64,  16'h0001, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_DRAW,  8'd255, 8'd255, 16'h8000, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_DRAW,  8'd5,   8'd9,   16'h0001, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_DRAW,  8'd5,   8'd9,   16'h0000, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_START, 8'd0,   8'd0,   16'h0000, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'hB0, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'h10, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'h01, 1'b1, 1'b0}},
      '{OP_DRAW,  8'd1,   8'd0,   16'h0004, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_PULL,  8'hFF,  8'hFF,  16'hFFFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_START, 8'hFF,  8'hFF,  16'hFFFF, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'hB0, 1'b0, 1'b0}},
      '{OP_FILL,  8'd0,   8'd0,   16'h0100, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'h10, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{OP_FILL,  8'd0,   8'd0,   16'h0000, 1'b0, '{8'h00, 1'b0, 1'b0}},
      '{OP_PULL,  8'd0,   8'd0,   16'h0000, 1'b1, '{8'h00, 1'b1, 1'b0}}
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i])
      send_item(plan[i].op, plan[i].x, plan[i].y, plan[i].color, plan[i].chk, plan[i].want);
    drain();

    while (n < MIN_ITEMS) begin
      next_phase = (n / PHASE_LEN) % 4;
      if (next_phase != phase) begin
        drain();
        phase = next_phase;
      end
      r  = $urandom_range(0, 999);
      px = 8'($urandom);
      py = 8'($urandom);
      c  = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
      ignored = 1'b0;
      if (flush_on) begin
        if (r < 800) o = OP_PULL;
        else if (r < 960) o = OP_DRAW;
        else if (r < 968) o = OP_FILL;
        else o = full_run ? OP_PULL : OP_START;
      end else begin
        if (r < 450) o = OP_DRAW;
        else if (r < 750) o = OP_START;
        else if (r < 800) o = OP_FILL;
        else begin
          o = OP_PULL;
          ignored = 1'b1;
        end
      end
      if (o == OP_DRAW) begin
        if ($urandom_range(0, 4) != 0) px = 8'($urandom_range(0, W - 1));
        if ($urandom_range(0, 4) != 0) py = 8'($urandom_range(0, H - 1));
      end
      if (o == OP_START) begin
        full_run = ($urandom_range(0, 2) == 0);
      end
      if (flush_on && !hold_done && n >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      send_item(o, px, py, c, 1'b0, '0);
      if (!ignored) n++;
    end

    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mopf_pkg.sv
rtl/mopf_ctrl.sv
rtl/mopf_dp.sv
rtl/mono_oled_page_buffer_flusher.sv
tb/sv/mono_oled_page_buffer_flusher_test.sv
